FILE: sv/osm_pkg.sv
// Package for the single-wire bus slot master: payload structs, operation,
// phase and register codes, reset values and timing constants.
// No dependencies.
`timescale 1ns / 1ps

package osm_pkg;

  localparam int unsigned CFG_W         = 10;
  localparam int unsigned NUM_CFG_REGS  = 7;
  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned SLOT_CNT_W    = 4;

  // Tail lengths of the slots in microseconds.
  localparam logic [CFG_W-1:0] ZERO_TAIL_US = 10'd30;
  localparam logic [CFG_W-1:0] ONE_TAIL_US  = 10'd50;
  localparam logic [CFG_W-1:0] READ_TAIL_US = 10'd47;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_RESET  = 3'd1,
    OP_WBIT   = 3'd2,
    OP_RBIT   = 3'd3,
    OP_WBYTE  = 3'd4,
    OP_RBYTE  = 3'd5,
    OP_PULLUP = 3'd6
  } osm_op_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LOW  = 2'd1,
    PH_WAIT = 2'd2,
    PH_TAIL = 2'd3
  } osm_phase_e;

  typedef enum logic [2:0] {
    REG_RESET_LOW     = 3'd0,
    REG_PRESENCE_WAIT = 3'd1,
    REG_RESET_TAIL    = 3'd2,
    REG_ZERO_LOW      = 3'd3,
    REG_ONE_LOW       = 3'd4,
    REG_READ_LOW      = 3'd5,
    REG_READ_WAIT     = 3'd6
  } osm_reg_e;

  typedef logic [NUM_CFG_REGS-1:0][CFG_W-1:0] osm_cfg_file_t;

  // Reset values, highest register index first.
  localparam osm_cfg_file_t CFG_RESET = {
    10'd11, 10'd2, 10'd10, 10'd90, 10'd420, 10'd70, 10'd500
  };

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_value;
    logic       line_level;
  } osm_in_t;

  typedef struct packed {
    logic       pull_low;
    logic       strong_high;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_value;
    logic       rejected;
  } osm_out_t;

  typedef struct packed {
    logic [2:0]       reg_index;
    logic [CFG_W-1:0] reg_data;
  } osm_cfg_t;

endpackage

FILE: sv/osm_chan_if.sv
// Valid/ready channel interface with a payload of any type.
// No dependencies; the payload types live in osm_pkg.
`timescale 1ns / 1ps

interface osm_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/onewire_slot_master_unit.sv
// Top level of the single-wire bus slot master: timing registers, slot
// sequencer and registered result stage.
// Depends on osm_pkg and osm_chan_if.
`timescale 1ns / 1ps

// The block takes one item per clock cycle: either a tick, which stands for one
// microsecond of bus time and carries the sampled line level, or a command
// (reset with presence detect, write bit, read bit, write byte, read byte sent
// least significant bit first, or strong pull-up). Every item yields exactly one
// result item, which enters the output register in the cycle after the item is
// accepted and shows the state after that item: line pull-down, strong pull-up,
// busy, done, presence, last read data and a rejection flag for a command given
// while a sequence runs. The whole update of the sequencer is a single pass of
// logic between the state registers and the result register, so the sustained
// rate is one item per cycle; the only thing that holds input back is a full
// result register that the consumer does not take in the same cycle. The seven
// timing registers may be rewritten at any time through the configuration
// channel, which is always ready; writes to index seven are ignored.

module onewire_slot_master_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  osm_chan_if.sink   in_i,
  osm_chan_if.source res_o,
  osm_chan_if.sink   cfg_i
);
  import osm_pkg::*;

  // Configuration registers.
  osm_cfg_file_t cfg_q;

  // Sequencer state.
  osm_phase_e                phase_q, phase_d;
  logic [CFG_W-1:0]          timer_q, timer_d;
  osm_op_e                   kind_q, kind_d;
  logic [SLOT_CNT_W-1:0]     slot_cnt_q, slot_cnt_d;
  logic [7:0]                shift_q, shift_d;
  logic                      presence_q, presence_d;
  logic                      pullup_q, pullup_d;
  logic [7:0]                read_hold_q, read_hold_d;

  // Result stage.
  osm_out_t out_q, out_d;
  logic     out_valid_q;

  logic             in_accept;
  logic             done;
  logic             rej;
  osm_op_e          op;
  logic [SLOT_CNT_W-1:0] slot_cnt_inc;
  logic [7:0]       shift_after;
  logic             read_like;

  // Low phase length at the start of a slot, chosen by command and data bit.
  function automatic logic [CFG_W-1:0] low_len(osm_cfg_file_t cfg, osm_op_e kind,
                                               logic bit0);
    logic [CFG_W-1:0] len;
    if (kind == OP_RESET) begin
      len = cfg[REG_RESET_LOW];
    end else if (kind == OP_RBIT || kind == OP_RBYTE) begin
      len = cfg[REG_READ_LOW];
    end else if (bit0) begin
      len = cfg[REG_ONE_LOW];
    end else begin
      len = cfg[REG_ZERO_LOW];
    end
    return len;
  endfunction

  // The input side stalls only when a result is waiting and is not taken now.
  assign in_i.ready  = !out_valid_q || res_o.ready;
  assign in_accept   = in_i.valid && in_i.ready;
  assign res_o.valid = out_valid_q;
  assign res_o.payload = out_q;
  assign cfg_i.ready = 1'b1;

  assign op           = osm_op_e'(in_i.payload.operation);
  assign read_like    = (kind_q == OP_RESET) || (kind_q == OP_RBIT) || (kind_q == OP_RBYTE);
  assign slot_cnt_inc = slot_cnt_q + 1'b1;
  // A write byte moves to its next bit at the end of each slot.
  assign shift_after  = (kind_q == OP_WBYTE) ? {1'b0, shift_q[7:1]} : shift_q;

  always_comb begin
    phase_d     = phase_q;
    timer_d     = timer_q;
    kind_d      = kind_q;
    slot_cnt_d  = slot_cnt_q;
    shift_d     = shift_q;
    presence_d  = presence_q;
    pullup_d    = pullup_q;
    read_hold_d = read_hold_q;
    done        = 1'b0;
    rej         = 1'b0;

    case (op)
      OP_TICK: begin
        if (phase_q != PH_IDLE) begin
          if (timer_q > 10'd1) begin
            timer_d = timer_q - 10'd1;
          end else begin
            unique case (phase_q)
              PH_LOW: begin
                if (read_like) begin
                  phase_d = PH_WAIT;
                  timer_d = (kind_q == OP_RESET) ? cfg_q[REG_PRESENCE_WAIT]
                                                 : cfg_q[REG_READ_WAIT];
                end else begin
                  phase_d = PH_TAIL;
                  timer_d = shift_q[0] ? ONE_TAIL_US : ZERO_TAIL_US;
                end
              end
              PH_WAIT: begin
                // Sample point: the line is read on the tick that ends the wait.
                if (kind_q == OP_RESET) begin
                  presence_d = !in_i.payload.line_level;
                end else if (kind_q == OP_RBIT) begin
                  read_hold_d = {7'd0, in_i.payload.line_level};
                end else begin
                  shift_d = {in_i.payload.line_level, shift_q[7:1]};
                end
                phase_d = PH_TAIL;
                timer_d = (kind_q == OP_RESET) ? cfg_q[REG_RESET_TAIL] : READ_TAIL_US;
              end
              PH_TAIL: begin
                shift_d    = shift_after;
                slot_cnt_d = slot_cnt_inc;
                if ((kind_q == OP_WBYTE || kind_q == OP_RBYTE) &&
                    slot_cnt_inc < SLOT_CNT_W'(BITS_PER_BYTE)) begin
                  phase_d = PH_LOW;
                  timer_d = low_len(cfg_q, kind_q, shift_after[0]);
                end else begin
                  if (kind_q == OP_RBYTE) begin
                    read_hold_d = shift_q;
                  end
                  phase_d = PH_IDLE;
                  timer_d = '0;
                  done    = 1'b1;
                end
              end
              default: begin
                phase_d = phase_q;
              end
            endcase
          end
        end
      end
      OP_RESET, OP_WBIT, OP_RBIT, OP_WBYTE, OP_RBYTE, OP_PULLUP: begin
        if (phase_q != PH_IDLE) begin
          rej = 1'b1;
        end else begin
          kind_d   = op;
          pullup_d = 1'b0;
          if (op == OP_PULLUP) begin
            pullup_d = 1'b1;
            done     = 1'b1;
          end else begin
            slot_cnt_d = '0;
            shift_d    = (op == OP_RBYTE) ? 8'd0 : in_i.payload.data_value;
            phase_d    = PH_LOW;
            timer_d    = low_len(cfg_q, op,
                                 (op == OP_RBYTE) ? 1'b0 : in_i.payload.data_value[0]);
          end
        end
      end
      default: begin
        // Undefined operation code: no time passes, nothing changes.
        rej = 1'b0;
      end
    endcase

    out_d.pull_low    = (phase_d == PH_LOW);
    out_d.strong_high = pullup_d;
    out_d.busy_res    = (phase_d != PH_IDLE);
    out_d.done_res    = done;
    out_d.presence    = presence_d;
    out_d.read_value  = read_hold_d;
    out_d.rejected    = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_i.valid && cfg_i.ready &&
                 cfg_i.payload.reg_index < 3'(NUM_CFG_REGS)) begin
      cfg_q[cfg_i.payload.reg_index] <= cfg_i.payload.reg_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      timer_q     <= '0;
      kind_q      <= OP_TICK;
      slot_cnt_q  <= '0;
      shift_q     <= '0;
      presence_q  <= 1'b0;
      pullup_q    <= 1'b0;
      read_hold_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        phase_q     <= phase_d;
        timer_q     <= timer_d;
        kind_q      <= kind_d;
        slot_cnt_q  <= slot_cnt_d;
        shift_q     <= shift_d;
        presence_q  <= presence_d;
        pullup_q    <= pullup_d;
        read_hold_q <= read_hold_d;
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The result payload needs no reset; it is only looked at while valid.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q <= out_d;
    end
  end

  // A rejected command can only happen while a sequence is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.rejected |-> out_q.busy_res)
    else $error("rejected result without busy");

  // A command never completes while the sequencer still reports busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.done_res |-> !out_q.busy_res)
    else $error("done and busy together");

  // The line is only pulled low inside a running sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.pull_low |-> out_q.busy_res)
    else $error("pull low while idle");

  // The phase timer is cleared whenever the sequencer is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> timer_q == '0)
    else $error("timer running while idle");

  // No command ever runs more slots than a byte holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_cnt_q <= SLOT_CNT_W'(BITS_PER_BYTE))
    else $error("slot count overrun");

endmodule
